// File: design/ppurp_pkg.sv
// Shared types, codes and memory sizes for the video-chip register port.
package ppurp_pkg;

   // Memory geometry
   localparam int PATTERN_BANK_BYTES = 4096;
   localparam int NAME_PAGE_BYTES    = 1024;
   localparam int SPRITE_BYTES       = 256;
   localparam int PALETTE_BYTES      = 32;

   localparam int PATTERN_DEPTH = 2 * PATTERN_BANK_BYTES;
   localparam int NAME_DEPTH    = 2 * NAME_PAGE_BYTES;
   localparam int PATTERN_AW    = $clog2(PATTERN_DEPTH);
   localparam int NAME_AW       = $clog2(NAME_DEPTH);
   localparam int SPRITE_AW     = $clog2(SPRITE_BYTES);
   localparam int PALETTE_AW    = $clog2(PALETTE_BYTES);

   // Bus commands
   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_VBLANK = 2'd2,
      CMD_CLEAR  = 2'd3
   } ppurp_cmd_type;

   // Register numbers
   localparam logic [2:0] REG_CONTROL   = 3'd0;
   localparam logic [2:0] REG_MASK      = 3'd1;
   localparam logic [2:0] REG_STATUS    = 3'd2;
   localparam logic [2:0] REG_OAM_INDEX = 3'd3;
   localparam logic [2:0] REG_OAM_DATA  = 3'd4;
   localparam logic [2:0] REG_SCROLL    = 3'd5;
   localparam logic [2:0] REG_ADDRESS   = 3'd6;
   localparam logic [2:0] REG_DATA      = 3'd7;

   // Nametable mirroring modes
   localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
   localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;

   // How the read byte is finished in the second stage
   typedef enum logic [1:0] {
      KIND_FIXED  = 2'd0,
      KIND_STATUS = 2'd1,
      KIND_SPRITE = 2'd2,
      KIND_DATA   = 2'd3
   } ppurp_kind_type;

   // Which memory feeds a data-port read
   typedef enum logic [1:0] {
      SRC_NONE    = 2'd0,
      SRC_PATTERN = 2'd1,
      SRC_NAME    = 2'd2,
      SRC_PALETTE = 2'd3
   } ppurp_src_type;

   // Memory accesses issued by the register file
   typedef struct packed {
      logic                  pat_we;
      logic                  pat_re;
      logic [PATTERN_AW-1:0] pat_addr;
      logic                  name_we;
      logic                  name_re;
      logic [NAME_AW-1:0]    name_addr;
      logic                  pal_we;
      logic                  pal_re;
      logic [PALETTE_AW-1:0] pal_addr;
      logic                  spr_we;
      logic                  spr_re;
      logic [SPRITE_AW-1:0]  spr_addr;
      logic [7:0]            wdata;
   } ppurp_mem_req_type;

   // What the second stage needs to build the response word
   typedef struct packed {
      ppurp_kind_type kind;
      ppurp_src_type  src;
      logic           direct;
      logic           gray;
      logic [7:0]     partial;
      logic           nmi;
   } ppurp_stage_type;

endpackage

// File: design/ppurp_ram.sv
// Generic single-port synchronous RAM with registered read data.
module ppurp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/ppurp_regs.sv
// Register file and address logic: updates state per word, issues memory accesses.
module ppurp_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [1:0]                   csr_wr_data,
   input  logic                         accept,
   input  logic [1:0]                   command,
   input  logic [2:0]                   reg_index,
   input  logic [7:0]                   write_data,
   input  logic                         peek,
   output ppurp_pkg::ppurp_mem_req_type mem_req,
   output ppurp_pkg::ppurp_stage_type   stage
);
   import ppurp_pkg::*;

   logic [1:0]  mirror_ff;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic [2:0]  status_ff, status_in;
   logic [2:0]  fine_x_ff, fine_x_in;
   logic        toggle_ff, toggle_in;
   logic [7:0]  spr_idx_ff, spr_idx_in;
   logic [15:0] cur_ff, cur_in;
   logic [14:0] tmp_ff, tmp_in;

   logic [13:0] vaddr;
   logic [15:0] step;
   logic        is_pattern;
   logic        is_palette;
   logic        name_mapped;
   ppurp_mem_req_type req;

   always_comb begin
      ctrl_in    = ctrl_ff;
      mask_in    = mask_ff;
      status_in  = status_ff;
      fine_x_in  = fine_x_ff;
      toggle_in  = toggle_ff;
      spr_idx_in = spr_idx_ff;
      cur_in     = cur_ff;
      tmp_in     = tmp_ff;

      // Decode the masked VRAM address
      vaddr       = cur_ff[13:0];
      step        = ctrl_ff[2] ? 16'd32 : 16'd1;
      is_pattern  = !vaddr[13];
      is_palette  = (vaddr[13:8] == 6'h3F);
      name_mapped = (mirror_ff == MIRROR_VERTICAL) || (mirror_ff == MIRROR_HORIZONTAL);

      req           = '0;
      req.pat_addr  = vaddr[PATTERN_AW-1:0];
      req.name_addr = (mirror_ff == MIRROR_HORIZONTAL) ? {vaddr[11], vaddr[9:0]}
                                                       : {vaddr[10], vaddr[9:0]};
      // Fold the four backdrop mirrors onto the lower half
      req.pal_addr  = {vaddr[4] & (vaddr[1:0] != 2'b00), vaddr[3:0]};
      req.spr_addr  = spr_idx_ff;
      req.wdata     = write_data;

      stage         = '0;
      stage.kind    = KIND_FIXED;
      stage.src     = SRC_NONE;
      stage.gray    = mask_ff[0];
      stage.direct  = (cur_ff[15:8] >= 8'h3F);

      case (command)
         CMD_READ: begin
            if (peek) begin
               case (reg_index)
                  REG_CONTROL: stage.partial = ctrl_ff;
                  REG_MASK:    stage.partial = mask_ff;
                  REG_STATUS:  stage.partial = {status_ff, 5'b0};
                  default:     stage.partial = 8'h00;
               endcase
            end else begin
               case (reg_index)
                  REG_STATUS: begin
                     stage.kind    = KIND_STATUS;
                     stage.partial = {status_ff, 5'b0};
                     status_in[2]  = 1'b0;
                     toggle_in     = 1'b0;
                  end
                  REG_OAM_DATA: begin
                     stage.kind = KIND_SPRITE;
                     req.spr_re = 1'b1;
                  end
                  REG_DATA: begin
                     stage.kind = KIND_DATA;
                     if (is_pattern) begin
                        stage.src  = SRC_PATTERN;
                        req.pat_re = 1'b1;
                     end else if (is_palette) begin
                        stage.src  = SRC_PALETTE;
                        req.pal_re = 1'b1;
                     end else if (name_mapped) begin
                        stage.src   = SRC_NAME;
                        req.name_re = 1'b1;
                     end
                     cur_in = cur_ff + step;
                  end
                  default: stage.kind = KIND_FIXED;
               endcase
            end
         end
         CMD_WRITE: begin
            case (reg_index)
               REG_CONTROL: begin
                  ctrl_in        = write_data;
                  tmp_in[11:10]  = write_data[1:0];
               end
               REG_MASK:      mask_in    = write_data;
               REG_OAM_INDEX: spr_idx_in = write_data;
               REG_OAM_DATA:  req.spr_we = 1'b1;
               REG_SCROLL: begin
                  if (!toggle_ff) begin
                     fine_x_in   = write_data[2:0];
                     tmp_in[4:0] = write_data[7:3];
                     toggle_in   = 1'b1;
                  end else begin
                     tmp_in[14:12] = write_data[2:0];
                     tmp_in[9:5]   = write_data[7:3];
                     toggle_in     = 1'b0;
                  end
               end
               REG_ADDRESS: begin
                  if (!toggle_ff) begin
                     tmp_in[14]   = 1'b0;
                     tmp_in[13:8] = write_data[5:0];
                     toggle_in    = 1'b1;
                  end else begin
                     tmp_in[7:0] = write_data;
                     cur_in      = {1'b0, tmp_ff[14:8], write_data};
                     toggle_in   = 1'b0;
                  end
               end
               REG_DATA: begin
                  if (is_pattern) begin
                     req.pat_we = 1'b1;
                  end else if (is_palette) begin
                     req.pal_we = 1'b1;
                  end else if (name_mapped) begin
                     req.name_we = 1'b1;
                  end
                  cur_in = cur_ff + step;
               end
               default: ctrl_in = ctrl_ff;
            endcase
         end
         CMD_VBLANK: begin
            status_in[2] = 1'b1;
            stage.nmi    = ctrl_ff[7];
         end
         CMD_CLEAR: status_in = 3'b000;
         default:   status_in = status_ff;
      endcase

      // Only an accepted word touches the memories
      mem_req         = req;
      mem_req.pat_we  = req.pat_we  & accept;
      mem_req.pat_re  = req.pat_re  & accept;
      mem_req.name_we = req.name_we & accept;
      mem_req.name_re = req.name_re & accept;
      mem_req.pal_we  = req.pal_we  & accept;
      mem_req.pal_re  = req.pal_re  & accept;
      mem_req.spr_we  = req.spr_we  & accept;
      mem_req.spr_re  = req.spr_re  & accept;
   end

   // Hold register state; advance on an accepted word; take the mirroring mode on a csr write
   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff  <= MIRROR_VERTICAL;
         ctrl_ff    <= '0;
         mask_ff    <= '0;
         status_ff  <= '0;
         fine_x_ff  <= '0;
         toggle_ff  <= 1'b0;
         spr_idx_ff <= '0;
         cur_ff     <= '0;
         tmp_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            mirror_ff <= csr_wr_data;
         end
         if (accept) begin
            ctrl_ff    <= ctrl_in;
            mask_ff    <= mask_in;
            status_ff  <= status_in;
            fine_x_ff  <= fine_x_in;
            toggle_ff  <= toggle_in;
            spr_idx_ff <= spr_idx_in;
            cur_ff     <= cur_in;
            tmp_ff     <= tmp_in;
         end
      end
   end

endmodule

// File: design/ppu_register_port_with_vram_core.sv
// Top level of the video-chip register port with its pattern, name, palette and sprite memories.
//
//   channel  | direction | handshake             | payload
//   req      | in        | req_tvalid/req_tready | command, reg_index, write_data, peek
//   rsp      | out       | rsp_tvalid/rsp_tready | read_data, nmi_request
//   csr      | in        | csr_wr_en             | mirroring mode (2 bits)
//
// One word enters per cycle while req_tready is high; its response passes the second stage,
// limited by the registered read of the memories (issue, then finish in the second stage),
// and then the output register. After reset a clearing pass zeroes all memories, walking
// the pattern memory depth, during which req_tready stays low; csr writes are taken throughout.
// A stalled response holds in the output register; one more word may wait in the
// second stage, after which req_tready drops until rsp_tready frees a slot.
module ppu_register_port_with_vram_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] command, [4:2] reg_index, [12:5] write_data, [13] peek, [15:14] zero
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] nmi_request, [15:9] zero
   output logic [15:0] rsp_tdata
);
   import ppurp_pkg::*;

   logic                  req_accept;
   logic [PATTERN_AW:0]   clr_ff, clr_in;
   logic                  clearing;
   ppurp_mem_req_type     mem_req;
   ppurp_stage_type       stage;

   logic                  s1_valid_ff, s1_valid_in;
   ppurp_stage_type       s1_ff;
   logic                  s1_adv;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [8:0]            rsp_data_ff;
   logic [7:0]            rb_ff;
   logic                  rb_load;

   logic [7:0] pat_rdata, name_rdata, pal_rdata, spr_rdata;
   logic [7:0] fetched;
   logic [7:0] rd;

   assign clearing   = !clr_ff[PATTERN_AW];
   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !clearing && (!s1_valid_ff || s1_adv);
   assign req_accept = req_tvalid && req_tready;

   ppurp_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (req_accept),
      .command     (req_tdata[1:0]),
      .reg_index   (req_tdata[4:2]),
      .write_data  (req_tdata[12:5]),
      .peek        (req_tdata[13]),
      .mem_req     (mem_req),
      .stage       (stage)
   );

   // Memories: the clearing pass owns the write ports until done
   ppurp_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pattern (
      .clock (clock),
      .we    (clearing | mem_req.pat_we),
      .re    (mem_req.pat_re),
      .addr  (clearing ? clr_ff[PATTERN_AW-1:0] : mem_req.pat_addr),
      .wdata (clearing ? 8'h00 : mem_req.wdata),
      .rdata (pat_rdata)
   );

   ppurp_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name (
      .clock (clock),
      .we    (clearing | mem_req.name_we),
      .re    (mem_req.name_re),
      .addr  (clearing ? clr_ff[NAME_AW-1:0] : mem_req.name_addr),
      .wdata (clearing ? 8'h00 : mem_req.wdata),
      .rdata (name_rdata)
   );

   ppurp_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_palette (
      .clock (clock),
      .we    (clearing | mem_req.pal_we),
      .re    (mem_req.pal_re),
      .addr  (clearing ? clr_ff[PALETTE_AW-1:0] : mem_req.pal_addr),
      .wdata (clearing ? 8'h00 : mem_req.wdata),
      .rdata (pal_rdata)
   );

   ppurp_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_sprite (
      .clock (clock),
      .we    (clearing | mem_req.spr_we),
      .re    (mem_req.spr_re),
      .addr  (clearing ? clr_ff[SPRITE_AW-1:0] : mem_req.spr_addr),
      .wdata (clearing ? 8'h00 : mem_req.wdata),
      .rdata (spr_rdata)
   );

   // Finish the read byte from memory data and the read buffer
   always_comb begin
      case (s1_ff.src)
         SRC_PATTERN: fetched = pat_rdata;
         SRC_NAME:    fetched = name_rdata;
         SRC_PALETTE: fetched = pal_rdata & (s1_ff.gray ? 8'h30 : 8'h3F);
         default:     fetched = 8'h00;
      endcase
      case (s1_ff.kind)
         KIND_STATUS: rd = s1_ff.partial | {3'b000, rb_ff[4:0]};
         KIND_SPRITE: rd = spr_rdata;
         KIND_DATA:   rd = s1_ff.direct ? fetched : rb_ff;
         default:     rd = s1_ff.partial;
      endcase
   end

   assign rb_load      = s1_valid_ff && s1_adv && (s1_ff.kind == KIND_DATA);
   assign clr_in       = clearing ? clr_ff + 1'b1 : clr_ff;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = (s1_valid_ff && s1_adv) || (rsp_valid_ff && !rsp_tready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rb_ff        <= '0;
      end else begin
         clr_ff       <= clr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rb_load) begin
            rb_ff <= fetched;
         end
      end
   end

   // Payload: load stage one on accept, output register when stage one moves on
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= stage;
      end
      if (s1_valid_ff && s1_adv) begin
         rsp_data_ff <= {s1_ff.nmi, rd};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

   // No word enters while the memories are being cleared
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_accept)
      else $error("word accepted during clearing pass");

   // A stalled second stage keeps its word
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("second stage dropped a stalled word");

   // A new response only comes out of the second stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(s1_valid_ff))
      else $error("response appeared without a word in stage one");

   // The read buffer moves only when a data-port read completes
   a_rb_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(rb_ff)) |-> $past(rb_load))
      else $error("read buffer changed outside a data read");

endmodule

// File: tb/ppu_register_port_with_vram_core_tb.sv
// Self-checking testbench for the video-chip register port: stream stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

module ppu_register_port_with_vram_core_tb;
   import ppurp_pkg::*;

   localparam logic [1:0] MIRROR_NONE = 2'd2;
   localparam int MAX_GAP        = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SWEEP_WORDS    = 300;
   localparam int CHUNK_WORDS    = 100;
   localparam int CHUNKS         = 7;

   typedef struct packed {
      ppurp_cmd_type cmd;
      logic [2:0]    idx;
      logic [7:0]    wd;
      logic          peek;
   } access_type;

   typedef struct packed {
      logic [7:0] rd;
      logic       nmi;
   } reply_type;

   typedef struct packed {
      access_type acc;
      logic       typed;
      reply_type  want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [1:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   // [1:0] command, [4:2] reg_index, [12:5] write_data, [13] peek, [15:14] zero
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [7:0] read_data, [8] nmi_request, [15:9] zero
   logic [15:0] rsp_tdata;

   // Predictor state
   logic [1:0]  mirror_mode;
   logic [7:0]  control_q;
   logic [7:0]  mask_q;
   logic [2:0]  flags_q;
   logic        toggle_q;
   logic [7:0]  buffer_q;
   logic [7:0]  oam_index_q;
   logic [15:0] vaddr_q;
   logic [15:0] taddr_q;
   logic [7:0]  pattern_mem [PATTERN_DEPTH];
   logic [7:0]  name_mem    [NAME_DEPTH];
   logic [7:0]  palette_mem [PALETTE_BYTES];
   logic [7:0]  sprite_mem  [SPRITE_BYTES];

   reply_type    pending_replies [$];
   stim_row_type stim_table [$];
   int          mismatch_count = 0;
   int          words_sent = 0;
   int          quiet_cycles = 0;
   bit          tx_gaps = 1'b1;
   bit          rx_gaps = 1'b1;
   bit          hold_off_pending = 1'b0;

   ppu_register_port_with_vram_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // End the run when no word moves on either channel for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Palette entries 0x10/0x14/0x18/0x1C fold onto 0x00/0x04/0x08/0x0C
   function automatic logic [4:0] palette_entry(input logic [4:0] a);
      return (a[4] && a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a;
   endfunction

   function automatic logic [7:0] vram_fetch(input logic [15:0] addr);
      logic [13:0] a;
      a = addr[13:0];
      if (a < 14'h2000) return pattern_mem[a[12:0]];
      if (a < 14'h3F00) begin
         if (mirror_mode == MIRROR_VERTICAL) return name_mem[{a[10], a[9:0]}];
         if (mirror_mode == MIRROR_HORIZONTAL) return name_mem[{a[11], a[9:0]}];
         return 8'h00;
      end
      return palette_mem[palette_entry(a[4:0])] & (mask_q[0] ? 8'h30 : 8'h3F);
   endfunction

   task automatic vram_store(input logic [15:0] addr, input logic [7:0] v);
      logic [13:0] a;
      a = addr[13:0];
      if (a < 14'h2000) pattern_mem[a[12:0]] = v;
      else if (a < 14'h3F00) begin
         // unmapped mirroring drops name writes
         if (mirror_mode == MIRROR_VERTICAL) name_mem[{a[10], a[9:0]}] = v;
         else if (mirror_mode == MIRROR_HORIZONTAL) name_mem[{a[11], a[9:0]}] = v;
      end else palette_mem[palette_entry(a[4:0])] = v;
   endtask

   // Work out the reply to one bus access and advance the port state
   task automatic predict_port_access(input access_type a, output reply_type r);
      logic [7:0] status_byte;
      r = '0;
      status_byte = {flags_q, 5'b00000};
      case (a.cmd)
         CMD_READ: begin
            if (a.peek) begin
               case (a.idx)
                  REG_CONTROL: r.rd = control_q;
                  REG_MASK:    r.rd = mask_q;
                  REG_STATUS:  r.rd = status_byte;
                  default: ;
               endcase
            end else if (a.idx == REG_STATUS) begin
               r.rd = {flags_q, buffer_q[4:0]};
               flags_q[2] = 1'b0;
               toggle_q = 1'b0;
            end else if (a.idx == REG_OAM_DATA) begin
               r.rd = sprite_mem[oam_index_q];
            end else if (a.idx == REG_DATA) begin
               // buffered unless the full 16-bit address is 0x3F00 or above
               r.rd = buffer_q;
               buffer_q = vram_fetch(vaddr_q);
               if (vaddr_q >= 16'h3F00) r.rd = buffer_q;
               vaddr_q = vaddr_q + (control_q[2] ? 16'd32 : 16'd1);
            end
         end
         CMD_WRITE: begin
            case (a.idx)
               REG_CONTROL: begin
                  control_q = a.wd;
                  taddr_q[11:10] = a.wd[1:0];
               end
               REG_MASK:      mask_q = a.wd;
               REG_OAM_INDEX: oam_index_q = a.wd;
               REG_OAM_DATA:  sprite_mem[oam_index_q] = a.wd;
               REG_SCROLL: begin
                  if (!toggle_q) taddr_q[4:0] = a.wd[7:3];
                  else begin
                     taddr_q[14:12] = a.wd[2:0];
                     taddr_q[9:5] = a.wd[7:3];
                  end
                  toggle_q = ~toggle_q;
               end
               REG_ADDRESS: begin
                  if (!toggle_q) taddr_q[15:8] = {2'b00, a.wd[5:0]};
                  else begin
                     taddr_q[7:0] = a.wd;
                     vaddr_q = taddr_q;
                  end
                  toggle_q = ~toggle_q;
               end
               REG_DATA: begin
                  vram_store(vaddr_q, a.wd);
                  vaddr_q = vaddr_q + (control_q[2] ? 16'd32 : 16'd1);
               end
               default: ;
            endcase
         end
         CMD_VBLANK: begin
            flags_q[2] = 1'b1;
            r.nmi = control_q[7];
         end
         default: flags_q = 3'b000;
      endcase
   endtask

   // Offer one word after a random gap; predict once it is taken
   task automatic send_access(input access_type a, input logic typed, input reply_type want);
      int gap;
      reply_type r;
      gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {2'b00, a.peek, a.wd, a.idx, a.cmd};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_port_access(a, r);
      pending_replies.push_back(typed ? want : r);
      words_sent++;
   endtask

   task automatic put(input ppurp_cmd_type c, input logic [2:0] i, input logic [7:0] w,
                      input logic p);
      access_type a;
      a.cmd = c;
      a.idx = i;
      a.wd = w;
      a.peek = p;
      send_access(a, 1'b0, '0);
   endtask

   task automatic add_row(input ppurp_cmd_type c, input logic [2:0] i, input logic [7:0] w,
                          input logic p, input logic typed, input logic [7:0] rd,
                          input logic nmi);
      stim_row_type row;
      row.acc.cmd = c;
      row.acc.idx = i;
      row.acc.wd = w;
      row.acc.peek = p;
      row.typed = typed;
      row.want.rd = rd;
      row.want.nmi = nmi;
      stim_table.push_back(row);
   endtask

   // Drop valid, wait for every reply, then let the pipeline go quiet
   task automatic drain_replies();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mirroring(input logic [1:0] mode);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = mode;
      @(negedge clock);
      csr_wr_en = 1'b0;
      mirror_mode = mode;
   endtask

   // One short sequence of random content, mostly well formed
   task automatic random_burst();
      int n;
      logic [7:0] hi;
      logic [7:0] lo;
      lo = 8'($urandom);
      case ($urandom_range(0, 3))
         0: hi = 8'($urandom);
         1: hi = {2'($urandom), 6'h20 + 6'($urandom_range(0, 30))};
         2: hi = {2'($urandom), 6'h3F};
         default: hi = {2'($urandom), 1'b0, 5'($urandom)};
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            // write a run, point back at its start and read it out
            if ($urandom_range(0, 3) != 0) put(CMD_READ, REG_STATUS, 8'($urandom), 1'b0);
            put(CMD_WRITE, REG_ADDRESS, hi, 1'($urandom));
            put(CMD_WRITE, REG_ADDRESS, lo, 1'($urandom));
            n = $urandom_range(1, 6);
            repeat (n) put(CMD_WRITE, REG_DATA, 8'($urandom), 1'($urandom));
            put(CMD_WRITE, REG_ADDRESS, hi, 1'($urandom));
            put(CMD_WRITE, REG_ADDRESS, lo, 1'($urandom));
            repeat (n + 1)
               put(CMD_READ, REG_DATA, 8'($urandom), $urandom_range(0, 7) == 0);
         end
         3: begin
            put(CMD_READ, REG_STATUS, 8'($urandom), 1'b0);
            put(CMD_WRITE, REG_SCROLL, 8'($urandom), 1'($urandom));
            put(CMD_WRITE, REG_SCROLL, 8'($urandom), 1'($urandom));
         end
         4: begin
            put(CMD_WRITE, REG_CONTROL, 8'($urandom), 1'($urandom));
            if ($urandom_range(0, 1)) put(CMD_WRITE, REG_MASK, 8'($urandom), 1'($urandom));
         end
         5: begin
            put(CMD_WRITE, REG_OAM_INDEX, 8'($urandom), 1'($urandom));
            repeat ($urandom_range(1, 3))
               put(CMD_WRITE, REG_OAM_DATA, 8'($urandom), 1'($urandom));
            put(CMD_READ, REG_OAM_DATA, 8'($urandom), $urandom_range(0, 3) == 0);
         end
         6: begin
            case ($urandom_range(0, 3))
               0: put(CMD_VBLANK, 3'($urandom), 8'($urandom), 1'($urandom));
               1: put(CMD_CLEAR, 3'($urandom), 8'($urandom), 1'($urandom));
               2: put(CMD_READ, REG_STATUS, 8'($urandom), 1'b0);
               default: put(CMD_READ, 3'($urandom), 8'($urandom), 1'b1);
            endcase
         end
         7: begin
            repeat ($urandom_range(1, 3))
               put(ppurp_cmd_type'(2'($urandom)), 3'($urandom), 8'($urandom), 1'($urandom));
         end
         8: begin
            repeat ($urandom_range(1, 4))
               put(CMD_READ, REG_DATA, 8'($urandom), $urandom_range(0, 7) == 0);
         end
         default: begin
            put(CMD_VBLANK, 3'($urandom), 8'($urandom), 1'($urandom));
            put(CMD_READ, REG_STATUS, 8'($urandom), 1'b0);
         end
      endcase
   endtask

   // Reply side: random stalls, one long hold-off on request, field checks
   initial begin
      int gap;
      reply_type got;
      reply_type want;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            gap = HOLD_CYCLES;
         end else gap = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.rd = rsp_tdata[7:0];
         got.nmi = rsp_tdata[8];
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected reply word", got.rd, 8'h00);
         end else begin
            want = pending_replies.pop_front();
            if (got.rd !== want.rd) report_mismatch("read_data", got.rd, want.rd);
            if (got.nmi !== want.nmi) report_mismatch("nmi_request", got.nmi, want.nmi);
         end
      end
   end

   // Request side and run sequencing
   initial begin
      int chunk;
      int target;
      int i;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      mirror_mode = MIRROR_VERTICAL;
      control_q = '0;
      mask_q = '0;
      flags_q = '0;
      toggle_q = 1'b0;
      buffer_q = '0;
      oam_index_q = '0;
      vaddr_q = '0;
      taddr_q = '0;
      foreach (pattern_mem[k]) pattern_mem[k] = '0;
      foreach (name_mem[k]) name_mem[k] = '0;
      foreach (palette_mem[k]) palette_mem[k] = '0;
      foreach (sprite_mem[k]) sprite_mem[k] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      set_mirroring(MIRROR_VERTICAL);

      // Directed table: register extremes, events, palette aliasing and grayscale
      add_row(CMD_READ,   REG_STATUS,    8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_READ,   REG_CONTROL,   8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_CONTROL,   8'hFF, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_VBLANK, REG_CONTROL,   8'h00, 1'b0, 1'b1, 8'h00, 1'b1);
      add_row(CMD_READ,   REG_STATUS,    8'h00, 1'b1, 1'b1, 8'h80, 1'b0);
      add_row(CMD_WRITE,  REG_MASK,      8'hFF, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_READ,   REG_MASK,      8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0);
      add_row(CMD_WRITE,  REG_ADDRESS,   8'hFF, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_ADDRESS,   8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_DATA,      8'hFF, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_CONTROL,   8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_ADDRESS,   8'h3F, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_ADDRESS,   8'h10, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_READ,   REG_DATA,      8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_MASK,      8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_READ,   REG_DATA,      8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
      add_row(CMD_READ,   REG_DATA,      8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
      add_row(CMD_VBLANK, REG_DATA,      8'hFF, 1'b1, 1'b1, 8'h00, 1'b0);
      add_row(CMD_READ,   REG_STATUS,    8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_SCROLL,    8'hFF, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_SCROLL,    8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_OAM_INDEX, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_OAM_DATA,  8'hA5, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_READ,   REG_OAM_DATA,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
      add_row(CMD_WRITE,  REG_STATUS,    8'hFF, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_CLEAR,  REG_STATUS,    8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
      add_row(CMD_READ,   REG_CONTROL,   8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
      foreach (stim_table[n])
         send_access(stim_table[n].acc, stim_table[n].typed, stim_table[n].want);
      drain_replies();

      // Set the address to 0x7FE0 through the scroll path, then walk it across bit 15
      set_mirroring(MIRROR_HORIZONTAL);
      put(CMD_WRITE, REG_CONTROL, 8'h04, 1'b0);
      put(CMD_READ, REG_STATUS, 8'h00, 1'b0);
      put(CMD_WRITE, REG_ADDRESS, 8'h3F, 1'b0);
      put(CMD_WRITE, REG_SCROLL, 8'hFF, 1'b0);
      put(CMD_WRITE, REG_SCROLL, 8'h07, 1'b0);
      put(CMD_WRITE, REG_ADDRESS, 8'hE0, 1'b0);
      for (i = 0; i < SWEEP_WORDS; i++) begin
         if ($urandom_range(0, 1))
            put(CMD_WRITE, REG_DATA, 8'($urandom), 1'($urandom));
         else
            put(CMD_READ, REG_DATA, 8'($urandom), $urandom_range(0, 15) == 0);
      end
      drain_replies();

      // Random chunks, each with its own mirroring mode and idling pattern
      for (chunk = 0; chunk < CHUNKS; chunk++) begin
         case (chunk)
            0: begin
               set_mirroring(MIRROR_VERTICAL);
               tx_gaps = 1'b0;
               rx_gaps = 1'b1;
               hold_off_pending = 1'b1;
            end
            1: begin
               set_mirroring(MIRROR_HORIZONTAL);
               tx_gaps = 1'b0;
               rx_gaps = 1'b0;
            end
            2: begin
               set_mirroring(MIRROR_NONE);
               tx_gaps = 1'b1;
               rx_gaps = 1'b1;
            end
            default: begin
               set_mirroring(2'($urandom_range(MIRROR_VERTICAL, MIRROR_NONE)));
               tx_gaps = $urandom_range(0, 3) != 0;
               rx_gaps = $urandom_range(0, 3) != 0;
            end
         endcase
         target = words_sent + CHUNK_WORDS;
         while (words_sent < target) random_burst();
         drain_replies();
      end

      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
